// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Whenever a holds, b must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: a implies b");
// The condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEVER(label, clk, rst_n, a)
`endif

`endif

// ----- hw/rtl/stp_pkg.sv -----
`timescale 1ns / 1ps

package stp_pkg;

	// fixed geometry of one packed block
	localparam int CHARS_PER_BLOCK = 10;
	localparam int BLOCK_BYTES     = 8;
	localparam int SLOTS           = 10;
	localparam int SLOT_W          = 6;
	localparam int WORD_W          = 8 * BLOCK_BYTES;
	localparam int SLOTS_W         = SLOTS * SLOT_W;
	localparam int CNT_W           = 4;
	localparam int BYTE_CNT_W      = $clog2(BLOCK_BYTES);

	// job queue between front and back end
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [SLOT_W-1:0] TERM_CODE = 6'd39;

	// input operations
	localparam logic [1:0] OP_ENC_CHAR = 2'd0;
	localparam logic [1:0] OP_ENC_END  = 2'd1;
	localparam logic [1:0] OP_DEC_BYTE = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// job kinds
	localparam logic [1:0] JOB_PACK   = 2'd0;
	localparam logic [1:0] JOB_DECODE = 2'd1;
	localparam logic [1:0] JOB_ERROR  = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] word;
	} job_t;

	// ASCII to code; bit 6 set when the character is supported
	function automatic logic [SLOT_W:0] char_code(input logic [7:0] ch);
		logic [SLOT_W:0] res;
		res = '0;
		if (ch inside {[8'h30:8'h39]}) begin
			res = {1'b1, SLOT_W'(ch - 8'h30)};
		end else if (ch inside {[8'h61:8'h7a]}) begin
			res = {1'b1, SLOT_W'(ch - 8'h61 + 8'd10)};
		end else begin
			case (ch)
				8'h20:   res = {1'b1, 6'd36};
				8'h2e:   res = {1'b1, 6'd37};
				8'h2c:   res = {1'b1, 6'd38};
				8'h00:   res = {1'b1, TERM_CODE};
				default: res = '0;
			endcase
		end
		return res;
	endfunction

	// code below the terminator to ASCII
	function automatic logic [7:0] code_char(input logic [SLOT_W-1:0] c);
		logic [7:0] res;
		if (c < 6'd10) begin
			res = 8'(c) + 8'h30;
		end else if (c < 6'd36) begin
			res = 8'(c) - 8'd10 + 8'h61;
		end else if (c == 6'd36) begin
			res = 8'h20;
		end else if (c == 6'd37) begin
			res = 8'h2e;
		end else begin
			res = 8'h2c;
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/sixbit_text_packer_core.sv -----
`timescale 1ns / 1ps
// Six-bit text packer. Encode characters (tuser 0) are mapped to 6-bit codes
// and an end item (tuser 1) emits the 8-byte block, or one error result if the
// text was too long or held an unsupported character. Packed bytes (tuser 2)
// are gathered eight at a time and unpacked into 1 to 10 characters, or one
// empty-text result. The input side takes one item per cycle; it stalls only
// when both entries of the two-deep job queue hold jobs that the output
// emitter has not started. The emitter loads a job and then gives one result
// per cycle while the receiver takes them. Input items keep being accepted
// while the emitter works on earlier jobs, until the queue is full.
`include "assert_macros.svh"

module sixbit_text_packer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data
	input  logic [1:0] s_axis_tuser,  // [1:0] op
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] value
	output logic [1:0] m_axis_tuser,  // [1:0] kind
	output logic       m_axis_tlast
);
	import stp_pkg::*;

	logic q_push, q_pop, q_full, q_empty;
	job_t push_job, head_job;

	stp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	stp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	stp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// queue never overflows or underflows
	`ASSERT_NEVER(a_no_overflow, clk, arst_n, q_push && q_full && !q_pop)
	`ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)
	// empty-text and error results are single-transaction runs
	`ASSERT_IMPLIES(a_single_last, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == KIND_EMPTY || m_axis_tuser == KIND_ERROR),
		m_axis_tlast)

endmodule

// ----- hw/rtl/stp_front.sv -----
`timescale 1ns / 1ps

module stp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_op,
	input  logic [7:0]    in_data,
	input  logic          q_full,
	output logic          q_push,
	output stp_pkg::job_t q_job
);
	import stp_pkg::*;

	localparam logic [SLOTS_W-1:0] ALL_TERM = {SLOTS{TERM_CODE}};

	logic [SLOTS_W-1:0]      slots_q, slots_d;
	logic [CNT_W-1:0]        char_cnt_q;
	logic                    bad_q;
	logic [WORD_W-9:0]       unpack_q;
	logic [BYTE_CNT_W-1:0]   byte_cnt_q;
	logic                    acc;
	logic [SLOT_W:0]         cc;
	logic                    block_done;

	assign in_ready   = !q_full;
	assign acc        = in_valid && in_ready;
	assign cc         = char_code(in_data);
	assign block_done = (byte_cnt_q == BYTE_CNT_W'(BLOCK_BYTES - 1));

	// place the new code in the next free slot, first character highest
	always_comb begin
		slots_d = slots_q;
		for (int i = 0; i < SLOTS; i++) begin
			if (char_cnt_q == CNT_W'(i))
				slots_d[SLOT_W*(SLOTS-1-i) +: SLOT_W] = cc[SLOT_W] ? cc[SLOT_W-1:0] : '0;
		end
	end

	// job for the back end on end of text or a full decode block
	always_comb begin
		q_push     = 1'b0;
		q_job.kind = JOB_PACK;
		q_job.word = {slots_q, 4'b0};
		if (acc && in_op == OP_ENC_END) begin
			q_push = 1'b1;
			if (bad_q || char_cnt_q > CNT_W'(CHARS_PER_BLOCK))
				q_job.kind = JOB_ERROR;
		end else if (acc && in_op == OP_DEC_BYTE && block_done) begin
			q_push     = 1'b1;
			q_job.kind = JOB_DECODE;
			q_job.word = {unpack_q, in_data};
		end
	end

	// encode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q    <= ALL_TERM;
			char_cnt_q <= '0;
			bad_q      <= 1'b0;
		end else if (acc && in_op == OP_ENC_CHAR) begin
			if (!cc[SLOT_W])
				bad_q <= 1'b1;
			if (char_cnt_q < CNT_W'(CHARS_PER_BLOCK)) begin
				slots_q    <= slots_d;
				char_cnt_q <= char_cnt_q + 1'b1;
			end else begin
				char_cnt_q <= CNT_W'(CHARS_PER_BLOCK + 1);
			end
		end else if (acc && in_op == OP_ENC_END) begin
			slots_q    <= ALL_TERM;
			char_cnt_q <= '0;
			bad_q      <= 1'b0;
		end
	end

	// decode byte gathering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (acc && in_op == OP_DEC_BYTE) begin
			byte_cnt_q <= block_done ? '0 : byte_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_op == OP_DEC_BYTE)
			unpack_q <= {unpack_q[WORD_W-17:0], in_data};
	end

endmodule

// ----- hw/rtl/stp_queue.sv -----
`timescale 1ns / 1ps

module stp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stp_pkg::job_t push_job,
	input  logic          pop,
	output stp_pkg::job_t head,
	output logic          full,
	output logic          empty
);
	import stp_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

// ----- hw/rtl/stp_back.sv -----
`timescale 1ns / 1ps

module stp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  stp_pkg::job_t q_head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_value,
	output logic [1:0]    out_kind,
	output logic          out_last
);
	import stp_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic                busy_q;
	logic [1:0]          job_kind_q;
	logic [WORD_W-1:0]   word_q;
	logic [IDX_W-1:0]    idx_q;
	logic                ovalid_q;
	logic [7:0]          value_q;
	logic [1:0]          kind_q;
	logic                last_q;
	logic                advance;
	logic [7:0]          nx_value;
	logic [1:0]          nx_kind;
	logic                nx_last;
	logic [SLOT_W-1:0]   code_cur, code_nxt;

	assign q_pop    = !busy_q && !q_empty;
	assign advance  = busy_q && (!ovalid_q || out_ready);
	assign code_cur = word_q[WORD_W-1 -: SLOT_W];
	assign code_nxt = word_q[WORD_W-1-SLOT_W -: SLOT_W];

	assign out_valid = ovalid_q;
	assign out_value = value_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

	// result for the current position of the job
	always_comb begin
		nx_value = '0;
		nx_kind  = KIND_ERROR;
		nx_last  = 1'b1;
		case (job_kind_q)
			JOB_PACK: begin
				nx_value = word_q[WORD_W-1 -: 8];
				nx_kind  = KIND_BYTE;
				nx_last  = (idx_q == IDX_W'(BLOCK_BYTES - 1));
			end
			JOB_DECODE: begin
				if (idx_q == '0 && code_cur >= TERM_CODE) begin
					nx_kind = KIND_EMPTY;
				end else begin
					nx_value = code_char(code_cur);
					nx_kind  = KIND_CHAR;
					nx_last  = (idx_q == IDX_W'(SLOTS - 1)) || (code_nxt >= TERM_CODE);
				end
			end
			default: begin
				nx_value = '0;
				nx_kind  = KIND_ERROR;
				nx_last  = 1'b1;
			end
		endcase
	end

	// job sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
		end else if (advance && nx_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_kind_q <= q_head.kind;
			word_q     <= q_head.word;
			idx_q      <= '0;
		end else if (advance) begin
			word_q <= (job_kind_q == JOB_PACK) ? {word_q[WORD_W-9:0], 8'h00}
			                                   : {word_q[WORD_W-1-SLOT_W:0], {SLOT_W{1'b0}}};
			idx_q  <= idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q <= nx_value;
			kind_q  <= nx_kind;
			last_q  <= nx_last;
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import stp_pkg::*;

	// op code that the block ignores
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 470;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] kind;
		logic       last;
	} text_result_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} text_item_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_e;

	// Tracks encode and decode state and the results still owed by the block
	class sixbit_scoreboard;
		bit [SLOTS_W-1:0] pack_shift;
		int unsigned      char_count;
		bit               bad_flag;
		bit [WORD_W-1:0]  unpack_shift;
		int unsigned      byte_count;
		text_result_t     expected_results[$];
		int               errors;

		function new();
			pack_shift   = '0;
			char_count   = 0;
			bad_flag     = 1'b0;
			unpack_shift = '0;
			byte_count   = 0;
			errors       = 0;
		endfunction

		// 6-bit code of an ASCII character, -1 when not in the alphabet
		function int code_of(logic [7:0] ch);
			if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30;
			if (ch >= 8'h61 && ch <= 8'h7a) return int'(ch) - 'h61 + 10;
			if (ch == 8'h20) return 36;
			if (ch == 8'h2e) return 37;
			if (ch == 8'h2c) return 38;
			if (ch == 8'h00) return int'(TERM_CODE);
			return -1;
		endfunction

		// character for a code below the terminator
		function logic [7:0] char_of(bit [5:0] c);
			if (c < 6'd10) return 8'h30 + 8'(c);
			if (c < 6'd36) return 8'h61 + 8'(c) - 8'd10;
			if (c == 6'd36) return 8'h20;
			if (c == 6'd37) return 8'h2e;
			return 8'h2c;
		endfunction

		// fill the unused slots with the terminator and pad to 64 bits
		function bit [WORD_W-1:0] seal_block(bit [SLOTS_W-1:0] codes, int unsigned count);
			bit [SLOTS_W-1:0] w;
			w = codes;
			for (int unsigned i = count; i < SLOTS; i++) begin
				w = {w[SLOTS_W-SLOT_W-1:0], TERM_CODE};
			end
			return {w, 4'b0000};
		endfunction

		// append one owed result at the tail
		function void expect_result(logic [7:0] value, logic [1:0] kind, logic last);
			text_result_t r;
			r.value = value;
			r.kind  = kind;
			r.last  = last;
			expected_results.insert(expected_results.size(), r);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		// accepted input transaction: update state, queue what it causes
		function void note_item(logic [1:0] op, logic [7:0] data);
			int code;
			int n;
			bit [WORD_W-1:0] word;
			bit [5:0] c;
			case (op)
				OP_ENC_CHAR: begin
					code = code_of(data);
					if (code < 0) bad_flag = 1'b1;
					if (char_count < CHARS_PER_BLOCK) begin
						pack_shift = {pack_shift[SLOTS_W-SLOT_W-1:0],
							(code < 0) ? 6'd0 : 6'(code)};
						char_count++;
					end else begin
						char_count = CHARS_PER_BLOCK + 1;
					end
				end
				OP_ENC_END: begin
					if (bad_flag || char_count > CHARS_PER_BLOCK) begin
						expect_result(8'h00, KIND_ERROR, 1'b1);
					end else begin
						word = seal_block(pack_shift, char_count);
						for (int i = 0; i < BLOCK_BYTES; i++) begin
							expect_result(word[WORD_W-1-8*i -: 8], KIND_BYTE,
								i == BLOCK_BYTES - 1);
						end
					end
					pack_shift = '0;
					char_count = 0;
					bad_flag   = 1'b0;
				end
				OP_DEC_BYTE: begin
					unpack_shift = {unpack_shift[WORD_W-9:0], data};
					if (byte_count == BLOCK_BYTES - 1) begin
						n = 0;
						for (int i = 0; i < SLOTS; i++) begin
							c = unpack_shift[WORD_W-1-SLOT_W*i -: SLOT_W];
							if (c >= TERM_CODE) break;
							expect_result(char_of(c), KIND_CHAR, 1'b0);
							n++;
						end
						if (n == 0) begin
							expect_result(8'h00, KIND_EMPTY, 1'b1);
						end else begin
							expected_results[expected_results.size()-1].last = 1'b1;
						end
						unpack_shift = '0;
						byte_count   = 0;
					end else begin
						byte_count++;
					end
				end
				default: ;
			endcase
		endfunction

		// accepted output transaction against the oldest expectation
		task check_result(logic [7:0] value, logic [1:0] kind, logic last);
			text_result_t exp;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result value %h kind %0d last %0b",
					value, kind, last));
				return;
			end
			exp = expected_results.pop_front();
			if (value !== exp.value)
				report($sformatf("value %h, expected %h", value, exp.value));
			if (kind !== exp.kind)
				report($sformatf("kind %0d, expected %0d", kind, exp.kind));
			if (last !== exp.last)
				report($sformatf("last %0b, expected %0b", last, exp.last));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic [1:0] s_axis_tuser = OP_NONE;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	sixbit_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	logic [31:0] rx_phase = '0;
	rx_mode_e    rx_mode = RX_ALWAYS;

	sixbit_text_packer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver backpressure in one of four randomly chosen modes
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_phase % 97 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_ALWAYS:   m_axis_tready <= 1'b1;
			RX_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_RARELY:   m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= rx_phase[2];
		endcase
	end

	// watch both sides for transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// append one item at the tail of a stimulus list
	function automatic void add_item(ref text_item_t q[$], input text_item_t it);
		q.insert(q.size(), it);
	endfunction

	// one input transaction, with bursts and gaps on the sender side
	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		if (op != OP_NONE) items_sent++;
	endtask

	task automatic send_all(ref text_item_t q[$]);
		foreach (q[i]) send_item(q[i].op, q[i].data);
	endtask

	// text to encode: mostly valid, some too long, a few bad characters
	task automatic build_encode(ref text_item_t q[$]);
		int unsigned sel;
		int unsigned len;
		int unsigned p;
		logic [7:0] ch;
		sel = $urandom_range(0, 9);
		len = (sel < 7) ? $urandom_range(0, 10) : (sel < 9) ? $urandom_range(11, 14) : 10;
		for (int unsigned i = 0; i < len; i++) begin
			p = $urandom_range(0, 99);
			if (p < 3) ch = 8'($urandom);
			else if (p < 6) ch = 8'h00;
			else ch = sb.char_of(6'($urandom_range(0, 38)));
			add_item(q, '{OP_ENC_CHAR, ch});
		end
		add_item(q, '{OP_ENC_END, 8'($urandom)});
	endtask

	// one block of 8 bytes to decode: mostly a well-formed packed text
	task automatic build_decode(ref text_item_t q[$]);
		bit [SLOTS_W-1:0] codes;
		bit [WORD_W-1:0]  word;
		int unsigned n;
		codes = '0;
		if ($urandom_range(0, 9) < 7) begin
			n = $urandom_range(0, 10);
			for (int unsigned i = 0; i < n; i++) begin
				codes = {codes[SLOTS_W-SLOT_W-1:0], 6'($urandom_range(0, 38))};
			end
			word = sb.seal_block(codes, n);
			word[3:0] = 4'($urandom);
		end else begin
			word = {$urandom, $urandom};
		end
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			add_item(q, '{OP_DEC_BYTE, word[WORD_W-1-8*i -: 8]});
		end
	endtask

	initial begin
		text_item_t enc_q[$];
		text_item_t dec_q[$];
		text_item_t run_q[$];
		string      text;
		int unsigned sel;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: whole alphabet range ends with an embedded NUL
		text = "09az .,";
		for (int i = 0; i < text.len(); i++) send_item(OP_ENC_CHAR, text[i]);
		send_item(OP_ENC_CHAR, 8'h00);
		send_item(OP_ENC_END, 8'h00);
		// empty text, then an unsupported character
		send_item(OP_ENC_END, 8'hff);
		send_item(OP_ENC_CHAR, 8'hff);
		send_item(OP_ENC_END, 8'h5a);
		// ignored op
		send_item(OP_NONE, 8'haa);
		// a block that starts with a code above the terminator decodes to nothing
		for (int i = 0; i < BLOCK_BYTES; i++) send_item(OP_DEC_BYTE, 8'hff);

		// random runs, some with encode and decode interleaved
		while (items_sent < ITEM_TARGET) begin
			enc_q.delete();
			dec_q.delete();
			run_q.delete();
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				build_encode(run_q);
			end else if (sel < 7) begin
				build_decode(run_q);
			end else if (sel < 9) begin
				build_encode(enc_q);
				build_decode(dec_q);
				while (enc_q.size() + dec_q.size() != 0) begin
					if (dec_q.size() == 0 || (enc_q.size() != 0 && $urandom_range(0, 1)))
						add_item(run_q, enc_q.pop_front());
					else
						add_item(run_q, dec_q.pop_front());
				end
			end else begin
				add_item(run_q, '{OP_NONE, 8'($urandom)});
				if ($urandom_range(0, 1)) add_item(run_q, '{OP_ENC_END, 8'($urandom)});
			end
			send_all(run_q);
		end
		s_axis_tvalid <= 1'b0;

		// drain
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
